[sv/btlv_pkg.sv]
package btlv_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TAG  = 3'd1,
        PH_LEN  = 3'd2,
        PH_LENX = 3'd3,
        PH_CMD  = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TAG_LONG   = 3'd1,
        ST_TAG_ZERO   = 3'd2,
        ST_BUF_EXH    = 3'd3,
        ST_LEN_FORM   = 3'd4,
        ST_VALUE_OVER = 3'd5
    } t_status;

    // One parsed header
    typedef struct packed {
        t_status     status;
        logic [31:0] tag;
        logic [31:0] len;
        logic [15:0] cmd;
        logic        present;
        logic [3:0]  offset;
    } t_result;

    // Proprietary tags that carry command bytes
    localparam logic [31:0] TAG_CMD2  = 32'h5F81_8101;
    localparam logic [31:0] TAG_CMD1A = 32'h5F84_8115;
    localparam logic [31:0] TAG_CMD1B = 32'h5F84_8110;

    localparam logic [4:0]  TAG_EXT_MASK  = 5'h1F;
    localparam logic [7:0]  LEN_LONG_BASE = 8'h80;
    localparam logic [7:0]  LEN_LONG_MIN  = 8'h81;
    localparam logic [7:0]  LEN_LONG_MAX  = 8'h84;
    localparam logic [3:0]  TAG_MAX_BYTES = 4'd4;
    localparam logic [3:0]  HDR_MAX_BYTES = 4'd9;

endpackage

[sv/btlv_in_if.sv]
interface btlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

[sv/btlv_out_if.sv]
interface btlv_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  parse_status;
    logic [31:0] tag_value;
    logic [31:0] value_length;
    logic [15:0] command_word;
    logic        command_present;
    logic [3:0]  value_offset;

    modport source (output valid, output parse_status, output tag_value, output value_length,
                    output command_word, output command_present, output value_offset,
                    input ready);
    modport sink   (input valid, input parse_status, input tag_value, input value_length,
                    input command_word, input command_present, input value_offset,
                    output ready);
endinterface

[sv/btlv_core.sv]
module btlv_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_data_byte,
    input  logic               i_first_byte,
    input  logic [15:0]        i_buffer_size,
    output logic               o_res_valid,
    output btlv_pkg::t_result  o_res
);
    import btlv_pkg::*;

    t_phase      r_phase, n_phase;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_len, n_len;
    logic [2:0]  r_lbl, n_lbl;
    logic [3:0]  r_hdr, n_hdr;
    logic [15:0] r_cmd, n_cmd;
    logic [1:0]  r_cbl, n_cbl;

    // header bytes reached the buffer; size zero acts as one
    function automatic logic f_exhausted(logic [3:0] h, logic [15:0] bs);
        logic [15:0] b1;
        b1 = (bs == 16'd0) ? 16'd1 : bs;
        return {12'd0, h} >= b1;
    endfunction

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tag   <= '0;
            r_len   <= '0;
            r_lbl   <= '0;
            r_hdr   <= '0;
            r_cmd   <= '0;
            r_cbl   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_lbl   <= n_lbl;
            r_hdr   <= n_hdr;
            r_cmd   <= n_cmd;
            r_cbl   <= n_cbl;
        end
    end

    // one byte step
    always_comb begin
        logic [3:0]  v_hdr1;
        logic [31:0] v_tag_sh;
        logic [31:0] v_len_sh;
        logic [2:0]  v_lbl_dec;
        logic [1:0]  v_cbl_dec;
        logic [15:0] v_cmd_sh;
        logic [1:0]  v_need;
        logic [1:0]  v_taken;
        logic        ld;
        logic [31:0] ld_len;
        logic [3:0]  ld_hdr;
        logic        fin;
        logic [31:0] fin_len;
        logic [3:0]  fin_hdr;
        logic [1:0]  fin_taken;
        logic [15:0] fin_cmd;
        logic [15:0] v_room;

        v_hdr1    = r_hdr + 4'd1;
        v_tag_sh  = {r_tag[23:0], i_data_byte};
        v_len_sh  = {r_len[23:0], i_data_byte};
        v_lbl_dec = (r_lbl != 3'd0) ? r_lbl - 3'd1 : 3'd0;
        v_cbl_dec = (r_cbl != 2'd0) ? r_cbl - 2'd1 : 2'd0;
        v_cmd_sh  = {r_cmd[7:0], i_data_byte};
        if (r_tag == TAG_CMD2) begin
            v_need = 2'd2;
        end else if (r_tag == TAG_CMD1A || r_tag == TAG_CMD1B) begin
            v_need = 2'd1;
        end else begin
            v_need = 2'd0;
        end
        v_taken   = (r_tag == TAG_CMD2) ? 2'd2 : 2'd1;
        ld        = 1'b0;
        ld_len    = r_len;
        ld_hdr    = v_hdr1;
        fin       = 1'b0;
        fin_len   = r_len;
        fin_hdr   = r_hdr;
        fin_taken = 2'd0;
        fin_cmd   = r_cmd;
        v_room    = '0;

        n_phase = r_phase;
        n_tag   = r_tag;
        n_len   = r_len;
        n_lbl   = r_lbl;
        n_hdr   = r_hdr;
        n_cmd   = r_cmd;
        n_cbl   = r_cbl;
        o_res_valid = 1'b0;
        o_res       = '0;
        o_res.status = ST_OK;

        if (i_first_byte) begin
            n_tag = {24'd0, i_data_byte};
            n_len = '0;
            n_lbl = '0;
            n_hdr = 4'd1;
            n_cmd = '0;
            n_cbl = '0;
            if (i_data_byte[4:0] == TAG_EXT_MASK) begin
                if (f_exhausted(4'd1, i_buffer_size)) begin
                    o_res_valid  = 1'b1;
                    o_res.status = ST_BUF_EXH;
                    n_phase      = PH_DONE;
                end else begin
                    n_phase = PH_TAG;
                end
            end else if (i_data_byte == 8'd0) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_TAG_ZERO;
                n_phase      = PH_DONE;
            end else if (f_exhausted(4'd1, i_buffer_size)) begin
                o_res_valid  = 1'b1;
                o_res.status = ST_BUF_EXH;
                o_res.tag    = {24'd0, i_data_byte};
                n_phase      = PH_DONE;
            end else begin
                n_phase = PH_LEN;
            end
        end else begin
            unique case (r_phase)
                PH_TAG: begin
                    n_hdr = v_hdr1;
                    n_tag = v_tag_sh;
                    if (i_data_byte[7]) begin
                        if (v_hdr1 >= TAG_MAX_BYTES) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_TAG_LONG;
                            n_phase      = PH_DONE;
                        end else if (f_exhausted(v_hdr1, i_buffer_size)) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_BUF_EXH;
                            n_phase      = PH_DONE;
                        end
                    end else if (f_exhausted(v_hdr1, i_buffer_size)) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_BUF_EXH;
                        o_res.tag    = v_tag_sh;
                        n_phase      = PH_DONE;
                    end else begin
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_hdr = v_hdr1;
                    if (i_data_byte >= LEN_LONG_MIN && i_data_byte <= LEN_LONG_MAX) begin
                        n_lbl = 3'(i_data_byte - LEN_LONG_BASE);
                        n_len = '0;
                        if (f_exhausted(v_hdr1, i_buffer_size)) begin
                            o_res_valid  = 1'b1;
                            o_res.status = ST_BUF_EXH;
                            o_res.tag    = r_tag;
                            n_phase      = PH_DONE;
                        end else begin
                            n_phase = PH_LENX;
                        end
                    end else if (i_data_byte[7]) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_LEN_FORM;
                        o_res.tag    = r_tag;
                        n_phase      = PH_DONE;
                    end else begin
                        n_len  = {24'd0, i_data_byte};
                        ld     = 1'b1;
                        ld_len = {24'd0, i_data_byte};
                    end
                end
                PH_LENX: begin
                    n_hdr = v_hdr1;
                    n_len = v_len_sh;
                    n_lbl = v_lbl_dec;
                    if (v_lbl_dec == 3'd0) begin
                        ld     = 1'b1;
                        ld_len = v_len_sh;
                    end else if (f_exhausted(v_hdr1, i_buffer_size)) begin
                        o_res_valid  = 1'b1;
                        o_res.status = ST_BUF_EXH;
                        o_res.tag    = r_tag;
                        n_phase      = PH_DONE;
                    end
                end
                PH_CMD: begin
                    n_cmd = v_cmd_sh;
                    n_cbl = v_cbl_dec;
                    if (v_cbl_dec == 2'd0) begin
                        n_len     = r_len - {30'd0, v_taken};
                        fin       = 1'b1;
                        fin_len   = r_len - {30'd0, v_taken};
                        fin_hdr   = r_hdr;
                        fin_taken = v_taken;
                        fin_cmd   = v_cmd_sh;
                    end
                end
                default: begin
                end
            endcase
        end

        // length complete: command bytes follow or finish now
        if (ld) begin
            if (v_need != 2'd0 && ld_len >= {30'd0, v_need}) begin
                n_cbl   = v_need;
                n_cmd   = '0;
                n_phase = PH_CMD;
            end else begin
                fin       = 1'b1;
                fin_len   = ld_len;
                fin_hdr   = ld_hdr;
                fin_taken = 2'd0;
            end
        end

        // final result with value room check
        if (fin) begin
            v_room = (i_buffer_size > {12'd0, fin_hdr}) ? i_buffer_size - {12'd0, fin_hdr}
                                                        : 16'd0;
            o_res_valid   = 1'b1;
            o_res.status  = (fin_len > {16'd0, v_room}) ? ST_VALUE_OVER : ST_OK;
            o_res.tag     = r_tag;
            o_res.len     = fin_len;
            o_res.cmd     = (fin_taken != 2'd0) ? fin_cmd : 16'd0;
            o_res.present = (fin_taken != 2'd0);
            o_res.offset  = fin_hdr + {2'd0, fin_taken};
            n_phase       = PH_DONE;
        end
    end

    // checks
    a_err_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status != ST_OK && o_res.status != ST_VALUE_OVER)
        |-> (o_res.len == 32'd0 && !o_res.present && o_res.offset == 4'd0))
        else $error("error result carries length or command");

    a_cmd_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.present) |-> (o_res.offset >= 4'd6))
        else $error("command result with short header");

    a_hold_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> ($stable(r_phase) && $stable(r_hdr)))
        else $error("parser state moved without a byte");

    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr <= HDR_MAX_BYTES)
        else $error("header byte count out of range");

endmodule

[sv/ber_tlv_header_parser.sv]
// Pipeline: an accepted byte is held in the input register and parsed combinationally by the core;
// its result is captured in the result register, which drives the output.
// Throughput: one byte per cycle; the result register and the input register stall only
// while a finished result waits downstream.
// Reset: synchronous, active low; clears the parser to idle and sets buffer_size to 200.
module ber_tlv_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    btlv_in_if.sink     i_in,
    btlv_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);
    import btlv_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_first;
    logic        r_out_valid;
    t_result     r_out;
    logic [15:0] r_buffer_size;

    logic        out_free;
    logic        step;
    logic        res_valid;
    t_result     res;

    assign out_free   = !r_out_valid || o_out.ready;
    assign step       = r_in_valid && out_free;
    assign i_in.ready = !r_in_valid || out_free;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= 16'd200;
        end else if (i_cfg_we) begin
            r_buffer_size <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte  <= i_in.data_byte;
            r_first <= i_in.first_byte;
        end
    end

    btlv_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_data_byte   (r_byte),
        .i_first_byte  (r_first),
        .i_buffer_size (r_buffer_size),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.parse_status    = r_out.status;
    assign o_out.tag_value       = r_out.tag;
    assign o_out.value_length    = r_out.len;
    assign o_out.command_word    = r_out.cmd;
    assign o_out.command_present = r_out.present;
    assign o_out.value_offset    = r_out.offset;

endmodule

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import btlv_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int SETTLE_TICKS = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_msg_byte;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    btlv_in_if  in_if ();
    btlv_out_if out_if ();

    ber_tlv_header_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Stimulus bookkeeping
    t_msg_byte message_bytes[$];
    t_result   parsed_headers[$];
    int        bytes_queued;
    int        bytes_accepted;
    int        mismatches;
    int        quiet_cycles;
    bit        steady;

    // Parser state mirror
    t_phase      parse_phase;
    logic [31:0] tag_acc;
    logic [31:0] len_acc;
    logic [2:0]  len_left;
    int unsigned hdr_seen;
    logic [15:0] cmd_acc;
    logic [1:0]  cmd_left;
    logic [15:0] buf_size;

    // Message bytes: bit 8 flags the first byte of a message
    logic [8:0] directed_bytes[] = '{
        9'h055,                                          // stray byte while idle
        9'h101, 9'h000,                                  // one-byte tag, empty value
        9'h100,                                          // zero tag
        9'h11F, 9'h081, 9'h082, 9'h083,                  // tag runs past four bytes
        9'h15F, 9'h081, 9'h081, 9'h001, 9'h002, 9'h0AB, 9'h0CD, // two command bytes
        9'h15F, 9'h084, 9'h081, 9'h015, 9'h081, 9'h003, 9'h07E, // one command byte
        9'h1FE, 9'h080,                                  // unsupported length form
        9'h102, 9'h084, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,  // value far beyond buffer
        9'h003,                                          // stray byte after a result
        9'h1C1, 9'h13F, 9'h07F, 9'h000                   // restart in mid header
    };

    // Buffer sizes walked through phase by phase
    logic [15:0] phase_sizes[] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd10, 16'd65535, 16'd200
    };

    function automatic bit buffer_exhausted();
        int unsigned lim;
        lim = (buf_size == 16'd0) ? 1 : int'(buf_size);
        return hdr_seen >= lim;
    endfunction

    function automatic t_result error_result(t_status st, logic [31:0] tag);
        t_result r;
        r = '0;
        r.status = st;
        r.tag = tag;
        return r;
    endfunction

    // Header complete: check value against what is left of the buffer
    function automatic t_result value_result(int unsigned taken);
        t_result r;
        logic [31:0] room;
        room = (int'(buf_size) > hdr_seen) ? 32'(int'(buf_size) - hdr_seen) : 32'd0;
        r.status  = (len_acc > room) ? ST_VALUE_OVER : ST_OK;
        r.tag     = tag_acc;
        r.len     = len_acc;
        r.cmd     = (taken != 0) ? cmd_acc : 16'd0;
        r.present = (taken != 0);
        r.offset  = 4'(hdr_seen + taken);
        return r;
    endfunction

    task automatic reset_parser_state();
        buf_size    = 16'd200;
        parse_phase = PH_IDLE;
        tag_acc     = '0;
        len_acc     = '0;
        len_left    = '0;
        hdr_seen    = 0;
        cmd_acc     = '0;
        cmd_left    = '0;
    endtask

    // Advance the parser mirror by one accepted byte
    task automatic parse_header_byte(input logic [7:0] b, input logic first,
                                     output bit got_result, output t_result res);
        bit tag_complete;
        bit len_complete;
        int unsigned need;
        int unsigned taken;
        got_result   = 0;
        res          = '0;
        tag_complete = 0;
        len_complete = 0;
        if (first) begin
            tag_acc  = {24'd0, b};
            len_acc  = '0;
            len_left = '0;
            hdr_seen = 1;
            cmd_acc  = '0;
            cmd_left = '0;
            if (b[4:0] == TAG_EXT_MASK) begin
                if (buffer_exhausted()) begin
                    got_result = 1;
                    res = error_result(ST_BUF_EXH, '0);
                end else begin
                    parse_phase = PH_TAG;
                end
            end else if (b == 8'd0) begin
                got_result = 1;
                res = error_result(ST_TAG_ZERO, '0);
            end else begin
                tag_complete = 1;
            end
        end else begin
            case (parse_phase)
                PH_TAG: begin
                    hdr_seen++;
                    tag_acc = {tag_acc[23:0], b};
                    if (b[7]) begin
                        if (hdr_seen >= TAG_MAX_BYTES) begin
                            got_result = 1;
                            res = error_result(ST_TAG_LONG, '0);
                        end else if (buffer_exhausted()) begin
                            got_result = 1;
                            res = error_result(ST_BUF_EXH, '0);
                        end
                    end else begin
                        tag_complete = 1;
                    end
                end
                PH_LEN: begin
                    hdr_seen++;
                    if (b >= LEN_LONG_MIN && b <= LEN_LONG_MAX) begin
                        len_left = 3'(b - LEN_LONG_BASE);
                        len_acc  = '0;
                        if (buffer_exhausted()) begin
                            got_result = 1;
                            res = error_result(ST_BUF_EXH, tag_acc);
                        end else begin
                            parse_phase = PH_LENX;
                        end
                    end else if (b >= LEN_LONG_BASE) begin
                        got_result = 1;
                        res = error_result(ST_LEN_FORM, tag_acc);
                    end else begin
                        len_acc = {24'd0, b};
                        len_complete = 1;
                    end
                end
                PH_LENX: begin
                    hdr_seen++;
                    len_acc = {len_acc[23:0], b};
                    if (len_left != 0) len_left = len_left - 3'd1;
                    if (len_left == 0) begin
                        len_complete = 1;
                    end else if (buffer_exhausted()) begin
                        got_result = 1;
                        res = error_result(ST_BUF_EXH, tag_acc);
                    end
                end
                PH_CMD: begin
                    cmd_acc = {cmd_acc[7:0], b};
                    if (cmd_left != 0) cmd_left = cmd_left - 2'd1;
                    if (cmd_left == 0) begin
                        taken = (tag_acc == TAG_CMD2) ? 2 : 1;
                        len_acc = len_acc - taken;
                        got_result = 1;
                        res = value_result(taken);
                    end
                end
                default: ;
            endcase
        end

        // tag finished: room must remain for the length byte
        if (tag_complete) begin
            if (buffer_exhausted()) begin
                got_result = 1;
                res = error_result(ST_BUF_EXH, tag_acc);
            end else begin
                parse_phase = PH_LEN;
            end
        end

        // length finished: proprietary tags pull command bytes first
        if (len_complete) begin
            need = 0;
            if (tag_acc == TAG_CMD2) need = 2;
            else if (tag_acc == TAG_CMD1A || tag_acc == TAG_CMD1B) need = 1;
            if (need != 0 && len_acc >= need) begin
                cmd_left    = 2'(need);
                cmd_acc     = '0;
                parse_phase = PH_CMD;
            end else begin
                got_result = 1;
                res = value_result(0);
            end
        end

        if (got_result) parse_phase = PH_DONE;
    endtask

    task automatic push_byte(input logic [7:0] b, input logic first);
        t_msg_byte mb;
        mb.data  = b;
        mb.first = first;
        message_bytes.push_back(mb);
        bytes_queued++;
    endtask

    // One message: mostly well formed headers with random content, some noise and cuts
    task automatic queue_random_message();
        logic [7:0]  msg[$];
        logic [7:0]  b;
        logic [31:0] ptag;
        int          sel;
        int          n;
        int          cut;
        sel = $urandom_range(99);
        if (sel < 6) begin
            n = $urandom_range(1, 4);
            repeat (n) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            return;
        end

        // tag
        sel = $urandom_range(99);
        if (sel < 25) begin
            case ($urandom_range(2))
                0:       ptag = TAG_CMD2;
                1:       ptag = TAG_CMD1A;
                default: ptag = TAG_CMD1B;
            endcase
            for (int i = 3; i >= 0; i--) msg.push_back(ptag[i*8 +: 8]);
        end else if (sel < 55) begin
            b = 8'($urandom_range(255));
            if (b[4:0] == TAG_EXT_MASK) b[0] = 1'b0;
            msg.push_back(b);
        end else if (sel < 59) begin
            msg.push_back(8'h00);
        end else begin
            msg.push_back({3'($urandom_range(7)), TAG_EXT_MASK});
            n = (sel < 92) ? $urandom_range(2) : $urandom_range(3, 4);
            repeat (n) msg.push_back(8'($urandom_range(255)) | 8'h80);
            if (sel < 92) msg.push_back(8'($urandom_range(127)));
        end

        // length
        sel = $urandom_range(99);
        if (sel < 50) begin
            if ($urandom_range(3) == 0) msg.push_back(8'($urandom_range(127)));
            else msg.push_back(8'($urandom_range(8)));
        end else if (sel < 85) begin
            n = $urandom_range(1, 4);
            msg.push_back(LEN_LONG_BASE + 8'(n));
            for (int i = 0; i < n; i++) begin
                if (i < n - 1 && $urandom_range(3) != 0) msg.push_back(8'h00);
                else msg.push_back(8'($urandom_range(255)));
            end
        end else if ($urandom_range(1) == 0) begin
            msg.push_back(LEN_LONG_BASE);
        end else begin
            msg.push_back(8'($urandom_range(8'h85, 8'hFF)));
        end

        // command bytes when wanted, then some value bytes the parser skips
        n = 2 + $urandom_range(3);
        repeat (n) msg.push_back(8'($urandom_range(255)));

        // occasionally cut short so the next message restarts mid header
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(1, msg.size() - 1);
            while (msg.size() > cut) void'(msg.pop_back());
        end

        foreach (msg[i]) push_byte(msg[i], i == 0);
    endtask

    // Wait until every byte is consumed and every result has arrived
    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || parsed_headers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_buffer_size(input logic [15:0] size);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        buf_size = size;
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sequence: reset, directed bytes, then random phases over buffer sizes
    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = '0;
        in_if.first_byte = 1'b0;
        out_if.ready     = 1'b0;
        bytes_queued     = 0;
        bytes_accepted   = 0;
        mismatches       = 0;
        steady           = 0;
        reset_parser_state();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_bytes[i]) push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
        wait_drained();

        for (int p = 0; p < 14; p++) begin
            if (p < phase_sizes.size()) write_buffer_size(phase_sizes[p]);
            else if (p % 2 == 0) write_buffer_size(16'($urandom_range(1, 24)));
            else write_buffer_size(16'($urandom_range(1, 65535)));
            steady = (p == 8);
            repeat (15) queue_random_message();
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Driver: next byte from the queue, with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (message_bytes.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
                in_if.valid      <= 1'b1;
                in_if.data_byte  <= message_bytes[0].data;
                in_if.first_byte <= message_bytes[0].first;
                void'(message_bytes.pop_front());
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= steady || ($urandom_range(99) >= 35);
        end
    end

    // Input monitor: each accepted byte steps the parser mirror
    always @(posedge i_clk) begin
        bit      has_result;
        t_result predicted;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            bytes_accepted++;
            parse_header_byte(in_if.data_byte, in_if.first_byte, has_result, predicted);
            if (has_result) parsed_headers.push_back(predicted);
        end
    end

    // Output monitor: compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            seen.status  = t_status'(out_if.parse_status);
            seen.tag     = out_if.tag_value;
            seen.len     = out_if.value_length;
            seen.cmd     = out_if.command_word;
            seen.present = out_if.command_present;
            seen.offset  = out_if.value_offset;
            if (parsed_headers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: st=%0d tag=%h len=%h cmd=%h pr=%b off=%0d",
                             seen.status, seen.tag, seen.len, seen.cmd, seen.present,
                             seen.offset);
            end else begin
                want = parsed_headers.pop_front();
                if (seen.status !== want.status || seen.tag !== want.tag ||
                    seen.len !== want.len || seen.cmd !== want.cmd ||
                    seen.present !== want.present || seen.offset !== want.offset) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch expected: st=%0d tag=%h len=%h cmd=%h pr=%b off=%0d",
                                 want.status, want.tag, want.len, want.cmd, want.present,
                                 want.offset);
                        $display("         actual:   st=%0d tag=%h len=%h cmd=%h pr=%b off=%0d",
                                 seen.status, seen.tag, seen.len, seen.cmd, seen.present,
                                 seen.offset);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial quiet_cycles = 0;

endmodule
